### design/glcw_pkg.sv
// Shared constants, codes and handshake structs of the grid line cell walker.
package glcw_pkg;

    // Field and register widths that the interface fixes.
    localparam int POS_W     = 24;
    localparam int VEL_W     = 24;
    localparam int SIZE_W    = 24;
    localparam int GRID_W    = 13;
    localparam int PROD_W    = POS_W + SIZE_W;
    localparam int REM_W     = PROD_W + 1;
    localparam int DIV_CNT_W = 6;
    localparam int MUL_CNT_W = 5;

    // Item function codes.
    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_STEP    = 2'd1;
    localparam logic [1:0] FUNC_ADVANCE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_CELL_SIZE_X = 2'd0;
    localparam logic [1:0] REG_CELL_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_CELLS_X     = 2'd2;
    localparam logic [1:0] REG_CELLS_Y     = 2'd3;

    // Sector start direction codes.
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    // Command to the serial divider: load its operands and run for steps iterations.
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_cmd_t;

    // Divider status: busy while iterating, done for one cycle when the quotient is ready.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### design/glcw_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module glcw_div #(
    parameter int QUOT_W = 40
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  glcw_pkg::div_cmd_t           cmd,
    input  logic [glcw_pkg::REM_W-1:0]   init_rem,
    input  logic [glcw_pkg::POS_W-1:0]   dividend,
    input  logic [glcw_pkg::PROD_W-1:0]  divisor,
    output glcw_pkg::div_stat_t          stat,
    output logic [QUOT_W-1:0]            quot
);

    logic [glcw_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           done_reg;
    logic [glcw_pkg::REM_W-1:0]     rem_reg;
    logic [glcw_pkg::POS_W-1:0]     dvd_reg;
    logic [glcw_pkg::PROD_W-1:0]    dsr_reg;
    logic [QUOT_W-1:0]              quot_reg;
    logic [glcw_pkg::REM_W-1:0]     shifted;
    logic [glcw_pkg::REM_W:0]       diff;
    logic                           fits;

    // The partial remainder stays below the divisor, so one bit of headroom suffices.
    assign shifted = {rem_reg[glcw_pkg::REM_W-2:0], dvd_reg[glcw_pkg::POS_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};
    assign fits    = ~diff[glcw_pkg::REM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            cnt_reg  <= cmd.steps;
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == glcw_pkg::DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg  <= init_rem;
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= fits ? diff[glcw_pkg::REM_W-1:0] : shifted;
            dvd_reg  <= {dvd_reg[glcw_pkg::POS_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quot      = quot_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cnt_reg) == glcw_pkg::DIV_CNT_W'(1))
        else $error("divider finished without a final iteration");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> cnt_reg == '0)
        else $error("divider restarted while still iterating");

    a_no_step_on_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> cmd.steps != '0)
        else $error("divider started with no iterations");

endmodule

### design/grid_line_cell_walker_core.sv
// Top level of the grid line cell walker: DDA walk over grid cells along a ray.
//
//  Channel  Signals                              Direction  Carries
//  cfg      cfg_we, cfg_addr, cfg_wdata          in         cell sizes and grid size
//  s        s_tvalid, s_tready, s_tdata, s_tuser in         start, step and advance items
//  m        m_tvalid, m_tready, m_tdata          out        one walk position per item
//
// Step and advance items load the result register at the same edge at which they are
// accepted. A start item runs the bit-serial divider twice for the start cell, then the
// shift-add multiplier, then the divider once more for the slope; the slope division
// is skipped when the velocity is zero or the slope saturates. Input is taken while
// the sequencer is idle and the result register is empty or its transfer completes in
// the same cycle, so a stalled output or a start sequence holds back new items.
// Reset clears the walk state and restores the configuration defaults; no clearing
// pass is needed.
module grid_line_cell_walker_core #(
    parameter int FRAC_BITS       = 16,
    parameter int CELL_INDEX_BITS = 14,
    localparam int OUT_W          = ((2 * CELL_INDEX_BITS + 3 + 7) / 8) * 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [23:0]          cfg_wdata,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [95:0]          s_tdata,   // pos_x[23:0], pos_y[47:24], vel_x[71:48], vel_y[95:72]
    input  logic [1:0]           s_tuser,   // func[1:0]
    // Output stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata    // cell_x, cell_y, inside_res, sector_start_dir, zeros
);

    localparam int F       = FRAC_BITS;
    localparam int CIB     = CELL_INDEX_BITS;
    localparam int ACC_W   = F + 2;
    localparam int SUM_W   = F + 3;
    localparam int SLOPE_W = F + 1;
    localparam int QUOT_W  = glcw_pkg::POS_W + F;
    localparam int CW      = (CIB > glcw_pkg::GRID_W) ? CIB : glcw_pkg::GRID_W;
    localparam int OUT_BITS = 2 * CIB + 3;

    localparam logic [glcw_pkg::DIV_CNT_W-1:0] DIV_STEPS   = glcw_pkg::DIV_CNT_W'(QUOT_W);
    localparam logic [glcw_pkg::DIV_CNT_W-1:0] RATIO_STEPS = glcw_pkg::DIV_CNT_W'(F);
    localparam logic [glcw_pkg::MUL_CNT_W-1:0] MUL_STEPS   =
        glcw_pkg::MUL_CNT_W'(glcw_pkg::VEL_W);

    localparam logic [SLOPE_W-1:0]      SLOPE_ONE = {1'b1, {F{1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_ONE   = {2'b01, {F{1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_MONE  = {2'b11, {F{1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_ONE   = {3'b001, {F{1'b0}}};

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIVX  = 3'd1;
    localparam logic [2:0] ST_DIVY  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_RSET  = 3'd4;
    localparam logic [2:0] ST_RATIO = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // Configuration registers.
    logic [glcw_pkg::SIZE_W-1:0] cell_size_x_reg, cell_size_y_reg;
    logic [glcw_pkg::GRID_W-1:0] cells_x_reg, cells_y_reg;

    // Walk state.
    logic [2:0]               state_reg, state_next;
    logic [CIB-1:0]           cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic                     major_is_x_reg, major_is_x_next;
    logic                     major_neg_reg, major_neg_next;
    logic                     minor_neg_reg, minor_neg_next;
    logic [SLOPE_W-1:0]       slope_reg, slope_next;
    logic signed [ACC_W-1:0]  accum_reg, accum_next;
    logic                     pending_reg, pending_next;
    logic                     walk_ok_reg, walk_ok_next;

    // Start datapath.
    logic [glcw_pkg::VEL_W-1:0]     ax_reg, ax_next, ay_reg, ay_next;
    logic [glcw_pkg::POS_W-1:0]     pos_y_reg, pos_y_next;
    logic [F-1:0]                   fx_reg, fx_next, fy_reg, fy_next;
    logic [glcw_pkg::PROD_W-1:0]    p1_reg, p1_next, p2_reg, p2_next;
    logic [glcw_pkg::MUL_CNT_W-1:0] mul_cnt_reg, mul_cnt_next;

    // Result register.
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]      out_data_reg, out_data_next;

    // Divider connection.
    glcw_pkg::div_cmd_t          div_cmd;
    glcw_pkg::div_stat_t         div_stat;
    logic [glcw_pkg::REM_W-1:0]  div_init;
    logic [glcw_pkg::POS_W-1:0]  div_dvd;
    logic [glcw_pkg::PROD_W-1:0] div_dsr;
    logic [QUOT_W-1:0]           div_quot;

    // Input fields.
    logic [1:0]                   in_func;
    logic [glcw_pkg::POS_W-1:0]   in_pos_x, in_pos_y;
    logic signed [glcw_pkg::VEL_W-1:0] in_vel_x, in_vel_y;
    logic [glcw_pkg::VEL_W-1:0]   in_abs_x, in_abs_y;

    logic [glcw_pkg::SIZE_W-1:0] size_x_eff, size_y_eff;
    logic                        in_fire, out_free;
    logic [glcw_pkg::PROD_W-1:0] ratio_n, ratio_m;

    // Combinational walk step.
    logic signed [SUM_W-1:0] acc_sum;
    logic                    acc_geq;
    logic signed [ACC_W-1:0] step_accum;
    logic                    step_pending, do_major, do_minor, do_check;
    logic                    x_move, x_dn, y_move, y_dn;
    logic [CIB-1:0]          step_x, step_y;
    logic                    off_grid;
    logic [1:0]              dir_now;

    // Start accumulator terms.
    logic [F-1:0]       f_minor, f_major;
    logic [SLOPE_W-1:0] s_term, l_term;
    logic signed [ACC_W-1:0] start_accum;

    assign in_func  = s_tuser;
    assign in_pos_x = s_tdata[23:0];
    assign in_pos_y = s_tdata[47:24];
    assign in_vel_x = s_tdata[71:48];
    assign in_vel_y = s_tdata[95:72];
    assign in_abs_x = in_vel_x[glcw_pkg::VEL_W-1] ? -in_vel_x : in_vel_x;
    assign in_abs_y = in_vel_y[glcw_pkg::VEL_W-1] ? -in_vel_y : in_vel_y;

    // A cell size of zero behaves as one.
    assign size_x_eff = (cell_size_x_reg == '0) ? glcw_pkg::SIZE_W'(1) : cell_size_x_reg;
    assign size_y_eff = (cell_size_y_reg == '0) ? glcw_pkg::SIZE_W'(1) : cell_size_y_reg;

    assign out_free = ~out_valid_reg | m_tready;
    assign s_tready = (state_reg == ST_IDLE) & out_free;
    assign in_fire  = s_tvalid & s_tready;

    // p1 = |vel_y| * size_x and p2 = |vel_x| * size_y; the major axis picks which
    // one is the numerator of the slope.
    assign ratio_n = major_is_x_reg ? p1_reg : p2_reg;
    assign ratio_m = major_is_x_reg ? p2_reg : p1_reg;

    // The accumulator is added the slope before each walk step but a diagonal's second
    // half; reaching one means the ray crossed into the next minor row or column first.
    always_comb
    begin
        acc_sum      = $signed({accum_reg[ACC_W-1], accum_reg}) + $signed({2'b00, slope_reg});
        acc_geq      = (acc_sum >= SUM_ONE);
        step_accum   = accum_reg;
        step_pending = pending_reg;
        do_major     = 1'b0;
        do_minor     = 1'b0;
        do_check     = 1'b0;
        case (in_func)
            glcw_pkg::FUNC_STEP:
            begin
                do_check = 1'b1;
                if (pending_reg)
                begin
                    // The second half of a diagonal move.
                    do_major     = 1'b1;
                    step_pending = 1'b0;
                end
                else if (acc_geq)
                begin
                    step_accum   = ACC_W'(acc_sum - SUM_ONE);
                    do_minor     = 1'b1;
                    step_pending = 1'b1;
                end
                else
                begin
                    step_accum = ACC_W'(acc_sum);
                    do_major   = 1'b1;
                end
            end
            glcw_pkg::FUNC_ADVANCE:
            begin
                do_major = 1'b1;
                if (acc_geq)
                begin
                    step_accum = ACC_W'(acc_sum - SUM_ONE);
                    do_minor   = 1'b1;
                end
                else
                begin
                    step_accum = ACC_W'(acc_sum);
                end
            end
            default:
            begin
                step_accum = accum_reg;
            end
        endcase

        x_move = major_is_x_reg ? do_major : do_minor;
        x_dn   = major_is_x_reg ? major_neg_reg : minor_neg_reg;
        y_move = major_is_x_reg ? do_minor : do_major;
        y_dn   = major_is_x_reg ? minor_neg_reg : major_neg_reg;
        step_x = x_move ? (cur_x_reg + (x_dn ? {CIB{1'b1}} : CIB'(1))) : cur_x_reg;
        step_y = y_move ? (cur_y_reg + (y_dn ? {CIB{1'b1}} : CIB'(1))) : cur_y_reg;

        // Cells are signed; a negative index or one at or past the grid size is off.
        off_grid = step_x[CIB-1] | (CW'(step_x) >= CW'(cells_x_reg)) |
                   step_y[CIB-1] | (CW'(step_y) >= CW'(cells_y_reg));
    end

    always_comb
    begin
        if (major_is_x_reg)
            dir_now = major_neg_reg ? glcw_pkg::DIR_UP : glcw_pkg::DIR_DOWN;
        else
            dir_now = major_neg_reg ? glcw_pkg::DIR_LEFT : glcw_pkg::DIR_RIGHT;
    end

    // Fractions into the start cell, mirrored for a negative direction.
    always_comb
    begin
        f_minor     = major_is_x_reg ? fy_reg : fx_reg;
        f_major     = major_is_x_reg ? fx_reg : fy_reg;
        s_term      = minor_neg_reg ? (SLOPE_ONE - {1'b0, f_minor}) : {1'b0, f_minor};
        l_term      = major_neg_reg ? (SLOPE_ONE - {1'b0, f_major}) : {1'b0, f_major};
        start_accum = $signed({1'b0, s_term}) - $signed({1'b0, l_term});
    end

    // Start sequencer and state update.
    always_comb
    begin
        state_next      = state_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        major_is_x_next = major_is_x_reg;
        major_neg_next  = major_neg_reg;
        minor_neg_next  = minor_neg_reg;
        slope_next      = slope_reg;
        accum_next      = accum_reg;
        pending_next    = pending_reg;
        walk_ok_next    = walk_ok_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        pos_y_next      = pos_y_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        mul_cnt_next    = mul_cnt_reg;
        out_valid_next  = out_valid_reg & ~m_tready;
        out_data_next   = out_data_reg;
        div_cmd.start   = 1'b0;
        div_cmd.steps   = DIV_STEPS;
        div_init        = '0;
        div_dvd         = in_pos_x;
        div_dsr         = glcw_pkg::PROD_W'(size_x_eff);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_func == glcw_pkg::FUNC_START)
                    begin
                        // Major axis is x only when its magnitude is strictly larger.
                        major_is_x_next = (in_abs_x > in_abs_y);
                        major_neg_next  = (in_abs_x > in_abs_y) ?
                                          in_vel_x[glcw_pkg::VEL_W-1] :
                                          in_vel_y[glcw_pkg::VEL_W-1];
                        minor_neg_next  = (in_abs_x > in_abs_y) ?
                                          in_vel_y[glcw_pkg::VEL_W-1] :
                                          in_vel_x[glcw_pkg::VEL_W-1];
                        ax_next         = in_abs_x;
                        ay_next         = in_abs_y;
                        pos_y_next      = in_pos_y;
                        div_cmd.start   = 1'b1;
                        state_next      = ST_DIVX;
                    end
                    else
                    begin
                        cur_x_next     = step_x;
                        cur_y_next     = step_y;
                        accum_next     = step_accum;
                        pending_next   = step_pending;
                        walk_ok_next   = walk_ok_reg & ~(do_check & off_grid);
                        out_valid_next = 1'b1;
                        out_data_next  = {dir_now, walk_ok_next, step_y, step_x};
                    end
                end
            end
            ST_DIVX:
            begin
                div_dvd = pos_y_reg;
                div_dsr = glcw_pkg::PROD_W'(size_y_eff);
                if (div_stat.done)
                begin
                    cur_x_next    = div_quot[F +: CIB];
                    fx_next       = div_quot[F-1:0];
                    div_cmd.start = 1'b1;
                    state_next    = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_stat.done)
                begin
                    cur_y_next   = div_quot[F +: CIB];
                    fy_next      = div_quot[F-1:0];
                    p1_next      = '0;
                    p2_next      = '0;
                    mul_cnt_next = MUL_STEPS;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // Shift-add multiply, one multiplier bit per cycle from the top.
                p1_next = {p1_reg[glcw_pkg::PROD_W-2:0], 1'b0} +
                          (ay_reg[glcw_pkg::VEL_W-1] ? glcw_pkg::PROD_W'(size_x_eff) : '0);
                p2_next = {p2_reg[glcw_pkg::PROD_W-2:0], 1'b0} +
                          (ax_reg[glcw_pkg::VEL_W-1] ? glcw_pkg::PROD_W'(size_y_eff) : '0);
                ay_next      = {ay_reg[glcw_pkg::VEL_W-2:0], 1'b0};
                ax_next      = {ax_reg[glcw_pkg::VEL_W-2:0], 1'b0};
                mul_cnt_next = mul_cnt_reg - 1'b1;
                if (mul_cnt_reg == glcw_pkg::MUL_CNT_W'(1))
                    state_next = ST_RSET;
            end
            ST_RSET:
            begin
                div_init      = glcw_pkg::REM_W'(ratio_n);
                div_dvd       = '0;
                div_dsr       = ratio_m;
                div_cmd.steps = RATIO_STEPS;
                if (ratio_m == '0 || ratio_n >= ratio_m)
                begin
                    // Zero velocity gives a flat slope; a ratio of one or more saturates.
                    slope_next   = (ratio_m == '0) ? '0 : SLOPE_ONE;
                    accum_next   = start_accum;
                    pending_next = 1'b0;
                    walk_ok_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    div_cmd.start = 1'b1;
                    state_next    = ST_RATIO;
                end
            end
            ST_RATIO:
            begin
                if (div_stat.done)
                begin
                    slope_next   = {1'b0, div_quot[F-1:0]};
                    accum_next   = start_accum;
                    pending_next = 1'b0;
                    walk_ok_next = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {dir_now, walk_ok_reg, cur_y_reg, cur_x_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    glcw_div #(
        .QUOT_W (QUOT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .init_rem (div_init),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .stat     (div_stat),
        .quot     (div_quot)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_x_reg <= glcw_pkg::SIZE_W'(256);
            cell_size_y_reg <= glcw_pkg::SIZE_W'(256);
            cells_x_reg     <= glcw_pkg::GRID_W'(64);
            cells_y_reg     <= glcw_pkg::GRID_W'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                glcw_pkg::REG_CELL_SIZE_X: cell_size_x_reg <= cfg_wdata;
                glcw_pkg::REG_CELL_SIZE_Y: cell_size_y_reg <= cfg_wdata;
                glcw_pkg::REG_CELLS_X:     cells_x_reg     <= cfg_wdata[glcw_pkg::GRID_W-1:0];
                glcw_pkg::REG_CELLS_Y:     cells_y_reg     <= cfg_wdata[glcw_pkg::GRID_W-1:0];
                default:                   cells_y_reg     <= cells_y_reg;
            endcase
        end
    end

    // Control and walk state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            major_is_x_reg <= 1'b0;
            major_neg_reg  <= 1'b0;
            minor_neg_reg  <= 1'b0;
            slope_reg      <= '0;
            accum_reg      <= '0;
            pending_reg    <= 1'b0;
            walk_ok_reg    <= 1'b0;
            mul_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            major_is_x_reg <= major_is_x_next;
            major_neg_reg  <= major_neg_next;
            minor_neg_reg  <= minor_neg_next;
            slope_reg      <= slope_next;
            accum_reg      <= accum_next;
            pending_reg    <= pending_next;
            walk_ok_reg    <= walk_ok_next;
            mul_cnt_reg    <= mul_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers of the start sequence and the result.
    always_ff @(posedge clk)
    begin
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        pos_y_reg    <= pos_y_next;
        fx_reg       <= fx_next;
        fy_reg       <= fy_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

    a_div_quiet_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_stat.busy)
        else $error("divider active outside a start sequence");

    a_start_enters_divx: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_func == glcw_pkg::FUNC_START) |=> state_reg == ST_DIVX)
        else $error("start item did not launch the cell division");

    a_slope_range: assert property (@(posedge clk) disable iff (!rst_n)
        slope_reg <= SLOPE_ONE)
        else $error("slope above one");

    a_accum_range: assert property (@(posedge clk) disable iff (!rst_n)
        (accum_reg <= ACC_ONE) && (accum_reg >= ACC_MONE))
        else $error("accumulator outside minus one to one");

    a_pending_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_func == glcw_pkg::FUNC_STEP && pending_reg) |=> !pending_reg)
        else $error("forced major step left the diagonal flag set");

endmodule
